[rtl/tmlp_pkg.sv]
`default_nettype none

package tmlp_pkg;

  localparam int DefaultOffsetBits = 16;

  localparam logic [15:0] EntryLimitReset = 16'hFFFF;
  localparam logic [15:0] CountMax        = 16'hFFFF;

  // register index, taken from the word address bit
  localparam logic RegEntryLimit = 1'b0;

  localparam logic [7:0] CharTab        = 8'h09;
  localparam logic [7:0] CharNewline    = 8'h0A;
  localparam logic [7:0] CharCr         = 8'h0D;
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharHash       = 8'h23;
  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] CharNine       = 8'h39;
  localparam logic [7:0] CharUpperA     = 8'h41;
  localparam logic [7:0] CharUpperZ     = 8'h5A;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharLowerA     = 8'h61;
  localparam logic [7:0] CharLowerZ     = 8'h7A;

  typedef enum logic [2:0] {
    MODE_LINE = 3'd0,
    MODE_SKIP = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_SEP  = 3'd3,
    MODE_NAME = 3'd4,
    MODE_ERR  = 3'd5
  } parse_mode_e;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } record_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_START  = 3'd1,
    ERR_TOO_LARGE  = 3'd2,
    ERR_NO_NAME    = 3'd3,
    ERR_BAD_NAME   = 3'd4,
    ERR_TOO_MANY   = 3'd5,
    ERR_NO_NEWLINE = 3'd6
  } error_code_e;

  typedef struct packed {
    record_kind_e record_kind;
    logic [31:0]  entry_number;
    logic [15:0]  name_offset;
    logic [15:0]  name_length;
    logic [15:0]  line_index;
    error_code_e  error_code;
    logic [15:0]  entry_total;
    logic         run_end;
  } result_t;

  // results handed to the output queue together, in the same cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [1:0] count;
    logic       free_one;
    logic       free_two;
  } fifo_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CharZero) && (b <= CharNine);
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return is_digit(b) || ((b >= CharLowerA) && (b <= CharLowerZ)) ||
           ((b >= CharUpperA) && (b <= CharUpperZ)) || (b == CharUnderscore);
  endfunction

endpackage

`default_nettype wire

[rtl/tmlp_in_if.sv]
`default_nettype none

interface tmlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink (input valid, input byte_value, input final_byte, output ready);
endinterface

`default_nettype wire

[rtl/tmlp_out_if.sv]
`default_nettype none

interface tmlp_out_if;
  import tmlp_pkg::*;

  logic         valid;
  logic         ready;
  record_kind_e record_kind;
  logic [31:0]  entry_number;
  logic [15:0]  name_offset;
  logic [15:0]  name_length;
  logic [15:0]  line_index;
  error_code_e  error_code;
  logic [15:0]  entry_total;
  logic         run_end;

  modport source (
    output valid, output record_kind, output entry_number, output name_offset,
    output name_length, output line_index, output error_code, output entry_total,
    output run_end, input ready
  );
  modport sink (
    input valid, input record_kind, input entry_number, input name_offset,
    input name_length, input line_index, input error_code, input entry_total,
    input run_end, output ready
  );
endinterface

`default_nettype wire

[rtl/tmlp_cfg_regs.sv]
`default_nettype none

module tmlp_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] entry_limit_o
);
  import tmlp_pkg::*;

  logic [15:0] limit_q;
  logic        hit;
  logic        wr_en;

  // byte address bits [1:0] are not decoded; only bit 2 selects the register
  assign hit    = (paddr[2] == RegEntryLimit);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= EntryLimitReset;
    end else if (wr_en) begin
      limit_q <= pwdata[15:0];
    end
  end

  assign prdata        = hit ? {16'b0, limit_q} : 32'b0;
  assign entry_limit_o = limit_q;

endmodule

`default_nettype wire

[rtl/tmlp_parse_core.sv]
`default_nettype none

module tmlp_parse_core #(
  parameter int OffsetBits = tmlp_pkg::DefaultOffsetBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tmlp_in_if.sink                req_i,
  input  logic [15:0]            entry_limit_i,
  input  tmlp_pkg::fifo_status_t fifo_st_i,
  output tmlp_pkg::push_t        push_o
);
  import tmlp_pkg::*;

  // input register
  logic       busy_q;
  logic [7:0] byte_q;
  logic       fin_q;

  // parser state
  parse_mode_e           mode_q, mode_d, mode_p;
  logic [31:0]           accum_q, accum_d;
  logic                  ovf_q, ovf_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] nstart_q, nstart_d;
  logic [15:0]           ncount_q, ncount_d;
  logic [15:0]           line_q, line_d;
  logic [15:0]           acc_q, acc_d;

  // step decisions
  error_code_e fail_code;
  logic        emit_entry;
  logic        num_start;
  logic        num_add;
  logic        name_begin;
  logic        name_inc;
  logic        line_inc;
  logic        is_nl;
  logic        has_first;
  logic [1:0]  need;
  logic        proceed;
  logic        in_ready;
  logic [35:0] num_next;
  result_t     res_item;
  result_t     res_done;

  assign is_nl = (byte_q == CharNewline);

  // next state of the line parser
  always_comb begin
    fail_code  = ERR_NONE;
    emit_entry = 1'b0;
    num_start  = 1'b0;
    num_add    = 1'b0;
    name_begin = 1'b0;
    name_inc   = 1'b0;
    mode_p     = mode_q;
    if (mode_q != MODE_ERR) begin
      if (fin_q && !is_nl) begin
        fail_code = ERR_NO_NEWLINE;
      end else begin
        unique case (mode_q)
          MODE_LINE: begin
            if (byte_q == CharHash) begin
              mode_p = MODE_SKIP;
            end else if (is_digit(byte_q)) begin
              if (acc_q >= entry_limit_i) begin
                fail_code = ERR_TOO_MANY;
              end else begin
                num_start = 1'b1;
                mode_p    = MODE_NUM;
              end
            end else if (!is_ws(byte_q)) begin
              fail_code = ERR_BAD_START;
            end
          end
          MODE_SKIP: begin
            if (is_nl) begin
              mode_p = MODE_LINE;
            end
          end
          MODE_NUM: begin
            if (is_digit(byte_q)) begin
              num_add = 1'b1;
            end else if (ovf_q) begin
              fail_code = ERR_TOO_LARGE;
            end else if (is_nl) begin
              fail_code = ERR_NO_NAME;
            end else if (is_ws(byte_q)) begin
              mode_p = MODE_SEP;
            end else begin
              fail_code = ERR_BAD_NAME;
            end
          end
          MODE_SEP: begin
            if (is_nl) begin
              fail_code = ERR_NO_NAME;
            end else if (is_name_char(byte_q)) begin
              name_begin = 1'b1;
              mode_p     = MODE_NAME;
            end else if (!is_ws(byte_q)) begin
              fail_code = ERR_BAD_NAME;
            end
          end
          MODE_NAME: begin
            if (is_name_char(byte_q)) begin
              name_inc = 1'b1;
            end else if (is_ws(byte_q)) begin
              emit_entry = 1'b1;
              mode_p     = is_nl ? MODE_LINE : MODE_SKIP;
            end else begin
              fail_code = ERR_BAD_NAME;
            end
          end
          default: mode_p = MODE_ERR;
        endcase
      end
    end
    if (fail_code != ERR_NONE) begin
      mode_p = MODE_ERR;
    end
    line_inc = is_nl && (mode_p != MODE_ERR) && (line_q != CountMax);
    mode_d   = fin_q ? MODE_LINE : mode_p;
  end

  // x10 as x8 + x2, plus the digit
  assign num_next = 36'({accum_q, 3'b000}) + 36'({accum_q, 1'b0}) + 36'(byte_q[3:0]);

  // datapath next values
  always_comb begin
    accum_d  = accum_q;
    ovf_d    = ovf_q;
    nstart_d = nstart_q;
    ncount_d = ncount_q;
    line_d   = line_q;
    acc_d    = acc_q;
    pos_d    = pos_q + OffsetBits'(1);
    if (fin_q) begin
      accum_d  = '0;
      ovf_d    = 1'b0;
      nstart_d = '0;
      ncount_d = '0;
      line_d   = 16'd1;
      acc_d    = '0;
      pos_d    = '0;
    end else begin
      if (num_start) begin
        accum_d = 32'(byte_q[3:0]);
        ovf_d   = 1'b0;
      end
      if (num_add) begin
        accum_d = num_next[31:0];
        ovf_d   = ovf_q || (num_next[35:32] != 4'b0);
      end
      if (name_begin) begin
        nstart_d = pos_q;
        ncount_d = 16'd1;
      end
      if (name_inc && (ncount_q != CountMax)) begin
        ncount_d = ncount_q + 16'd1;
      end
      if (emit_entry) begin
        acc_d = acc_q + 16'd1;
      end
      line_d = line_q + 16'(line_inc);
    end
  end

  // result records
  always_comb begin
    has_first = emit_entry || (fail_code != ERR_NONE);
    need      = 2'(has_first) + 2'(fin_q);

    res_item.record_kind  = emit_entry ? KIND_ENTRY : KIND_ERROR;
    res_item.entry_number = emit_entry ? accum_q : 32'b0;
    res_item.name_offset  = emit_entry ? 16'(nstart_q) : 16'b0;
    res_item.name_length  = emit_entry ? ncount_q : 16'b0;
    res_item.line_index   = line_q;
    res_item.error_code   = fail_code;
    res_item.entry_total  = acc_q + 16'(emit_entry);
    res_item.run_end      = !fin_q;

    res_done.record_kind  = KIND_DONE;
    res_done.entry_number = 32'b0;
    res_done.name_offset  = 16'b0;
    res_done.name_length  = 16'b0;
    res_done.line_index   = line_q + 16'(line_inc);
    res_done.error_code   = ERR_NONE;
    res_done.entry_total  = acc_q + 16'(emit_entry);
    res_done.run_end      = 1'b1;
  end

  always_comb begin
    unique case (need)
      2'd0:    proceed = busy_q;
      2'd1:    proceed = busy_q && fifo_st_i.free_one;
      default: proceed = busy_q && fifo_st_i.free_two;
    endcase
  end

  assign in_ready    = !busy_q || proceed;
  assign req_i.ready = in_ready;

  assign push_o.count  = proceed ? need : 2'd0;
  assign push_o.first  = has_first ? res_item : res_done;
  assign push_o.second = res_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_ready) begin
      busy_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      byte_q <= req_i.byte_value;
      fin_q  <= req_i.final_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINE;
      pos_q  <= '0;
      line_q <= 16'd1;
      acc_q  <= '0;
    end else if (proceed) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      line_q <= line_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      accum_q  <= accum_d;
      ovf_q    <= ovf_d;
      nstart_q <= nstart_d;
      ncount_q <= ncount_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tmlp_out_fifo.sv]
`default_nettype none

module tmlp_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tmlp_pkg::push_t        push_i,
  output tmlp_pkg::fifo_status_t status_o,
  tmlp_out_if.source             res_o
);
  import tmlp_pkg::*;

  result_t    slot_q [2];
  result_t    slot_d [2];
  logic [1:0] count_q, count_d;
  logic [1:0] base;
  logic       pop;

  assign pop = res_o.valid && res_o.ready;

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    base      = count_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      base      = count_q - 2'd1;
    end
    if (push_i.count != 2'd0) begin
      slot_d[base[0]] = push_i.first;
    end
    // a pair only comes in when the queue is empty
    if (push_i.count == 2'd2) begin
      slot_d[1] = push_i.second;
    end
    count_d = base + push_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign status_o.count    = count_q;
  assign status_o.free_one = (count_q != 2'd2);
  assign status_o.free_two = (count_q == 2'd0);

  assign res_o.valid        = (count_q != 2'd0);
  assign res_o.record_kind  = slot_q[0].record_kind;
  assign res_o.entry_number = slot_q[0].entry_number;
  assign res_o.name_offset  = slot_q[0].name_offset;
  assign res_o.name_length  = slot_q[0].name_length;
  assign res_o.line_index   = slot_q[0].line_index;
  assign res_o.error_code   = slot_q[0].error_code;
  assign res_o.entry_total  = slot_q[0].entry_total;
  assign res_o.run_end      = slot_q[0].run_end;

endmodule

`default_nettype wire

[rtl/tag_map_line_parser.sv]
`default_nettype none

// Tag map line parser: takes map text one byte per request on in_req, the last
// byte flagged by final_byte, and sends entry, error and done records on out_res.
// Each accepted byte lands in an input register; combinational parse logic
// (character classes, a x10-plus-digit add on the 32-bit tag number, position
// and line counters) updates the parser state and writes zero, one or two
// records into a two-entry result queue that drives out_res. Throughput is one
// byte per cycle while out_res keeps up; a byte's records pass the input
// register and then the result queue on their way to out_res. A final byte that
// makes two records (an error or entry and then the done record) waits in the
// input register until the queue is empty. After an error the parser ignores
// bytes until the final one; after the final byte all state returns to its reset
// value while entry_limit keeps its value. entry_limit sits at APB byte address
// 0. The user must write it only while the block is idle; nothing enforces it.
module tag_map_line_parser #(
  parameter int OffsetBits = tmlp_pkg::DefaultOffsetBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmlp_in_if.sink     in_req,
  tmlp_out_if.source  out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmlp_pkg::*;

  logic [15:0]  entry_limit;
  fifo_status_t fifo_st;
  push_t        push;

  // configuration register
  tmlp_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .entry_limit_o (entry_limit)
  );

  // input register plus parse step
  tmlp_parse_core #(
    .OffsetBits (OffsetBits)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (in_req),
    .entry_limit_i (entry_limit),
    .fifo_st_i     (fifo_st),
    .push_o        (push)
  );

  // result queue, decouples out_res backpressure from the parser
  tmlp_out_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .status_o (fifo_st),
    .res_o    (out_res)
  );

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |=> (fifo_st.count != 2'd3))
    else $error("result queue overflow");

  // the done record closes the burst of its byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_res.valid && (out_res.record_kind == KIND_DONE)) |-> out_res.run_end)
    else $error("done record without run_end");

  // entries carry a nonempty name and no error
  a_entry_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_res.valid && (out_res.record_kind == KIND_ENTRY)) |->
      ((out_res.error_code == ERR_NONE) && (out_res.name_length != 16'd0)))
    else $error("malformed entry record");

  // error records always name a cause
  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_res.valid && (out_res.record_kind == KIND_ERROR)) |->
      (out_res.error_code != ERR_NONE))
    else $error("error record without code");

endmodule

`default_nettype wire
